// ===== sv/ibpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibpp_pkg
// shared types and constants of the binary packet parser
// ----------------------------------------------------------------------------
package ibpp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

    // only the first bytes of a payload ever reach a result
    localparam int KEEP_BYTES = 12;
    localparam int IDX_W = $clog2(KEEP_BYTES);

    localparam int TOK_DEPTH = 4;
    localparam int TQ_AW = $clog2(TOK_DEPTH);
    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW = $clog2(RQ_DEPTH);

    localparam logic [7:0] SYNC_S = 8'h73;
    localparam logic [7:0] SYNC_N = 8'h6E;
    localparam logic [7:0] SYNC_P = 8'h70;
    localparam logic [15:0] SYNC_SUM = 16'(115 + 110 + 112);

    localparam logic [7:0] ADDR_QUAT = 8'd109;
    localparam logic [7:0] ADDR_GYRO = 8'd97;
    localparam logic [7:0] ADDR_ACCEL = 8'd101;

    localparam int HAS_DATA_BIT = 7;
    localparam int BATCH_BIT = 6;
    localparam logic [3:0] QUAT_MIN_BATCH = 4'd2;
    localparam logic [3:0] VEC_MIN_BATCH = 4'd3;

    localparam logic [1:0] CFG_ORIENT = 2'd0;
    localparam logic [1:0] CFG_GYRO = 2'd1;
    localparam logic [1:0] CFG_ACCEL = 2'd2;

    typedef enum logic [1:0] {
        KIND_QUAT  = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ACCEL = 2'd2
    } t_kind;

    typedef enum logic [7:0] {
        PH_HUNT = 8'b0000_0001,
        PH_N    = 8'b0000_0010,
        PH_P    = 8'b0000_0100,
        PH_TYPE = 8'b0000_1000,
        PH_ADDR = 8'b0001_0000,
        PH_PAY  = 8'b0010_0000,
        PH_CKH  = 8'b0100_0000,
        PH_CKL  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic en_orient;
        logic en_gyro;
        logic en_accel;
    } t_cfg;

    // last = packet passed all checks, emit a result of this kind
    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        t_kind            kind;
    } t_tok;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [15:0] word_d;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/ibpp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibpp_front
// framing state machine: sync hunt, header, checksum; emits byte tokens and result tokens
// ----------------------------------------------------------------------------
module ibpp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire ibpp_pkg::t_cfg i_cfg,
    output logic               o_tok_push,
    output ibpp_pkg::t_tok     o_tok
);
    import ibpp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_addr, n_addr;
    logic [5:0]  r_len, n_len;
    logic [5:0]  r_count, n_count;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_ckh, n_ckh;

    logic [5:0] w_len;
    logic [3:0] w_blen;
    logic       w_batch;
    logic       w_match;
    logic       w_quat;
    logic       w_vec;

    assign w_len   = i_byte[BATCH_BIT] ? {i_byte[5:2], 2'b00} : 6'd4;
    assign w_blen  = r_type[5:2];
    assign w_batch = r_type[BATCH_BIT];
    assign w_match = ({r_ckh, i_byte} == r_sum);
    assign w_quat  = i_cfg.en_orient && (r_addr == ADDR_QUAT) && w_batch
                     && (w_blen >= QUAT_MIN_BATCH);
    assign w_vec   = ((i_cfg.en_gyro && (r_addr == ADDR_GYRO))
                     || (i_cfg.en_accel && (r_addr == ADDR_ACCEL)))
                     && w_batch && (w_blen >= VEC_MIN_BATCH);

    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_addr     = r_addr;
        n_len      = r_len;
        n_count    = r_count;
        n_sum      = r_sum;
        n_ckh      = r_ckh;
        o_tok_push = 1'b0;
        o_tok.last = 1'b0;
        o_tok.idx  = r_count[IDX_W-1:0];
        o_tok.data = i_byte;
        o_tok.kind = KIND_QUAT;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == SYNC_S) n_phase = PH_N;
                end
                PH_N: n_phase = (i_byte == SYNC_N) ? PH_P : PH_HUNT;
                PH_P: n_phase = (i_byte == SYNC_P) ? PH_TYPE : PH_HUNT;
                PH_TYPE: begin
                    n_type = i_byte;
                    if ({1'b0, w_len} > MAX_LEN) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_len   = w_len;
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    n_addr  = i_byte;
                    n_count = '0;
                    n_sum   = SYNC_SUM + {8'd0, r_type} + {8'd0, i_byte};
                    if (!r_type[HAS_DATA_BIT]) n_phase = PH_HUNT;
                    else if (r_len == '0) n_phase = PH_CKH;
                    else n_phase = PH_PAY;
                end
                PH_PAY: begin
                    n_sum   = r_sum + {8'd0, i_byte};
                    n_count = r_count + 6'd1;
                    if (r_count < 6'(KEEP_BYTES)) o_tok_push = 1'b1;
                    if (({1'b0, r_count} + 7'd1) >= {1'b0, r_len}) n_phase = PH_CKH;
                end
                PH_CKH: begin
                    n_ckh   = i_byte;
                    n_phase = PH_CKL;
                end
                PH_CKL: begin
                    n_phase = PH_HUNT;
                    if (w_match && (w_quat || w_vec)) begin
                        o_tok_push = 1'b1;
                        o_tok.last = 1'b1;
                        if (w_quat) o_tok.kind = KIND_QUAT;
                        else if (r_addr == ADDR_GYRO) o_tok.kind = KIND_GYRO;
                        else o_tok.kind = KIND_ACCEL;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_type  <= '0;
            r_addr  <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_ckh   <= '0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_ckh   <= n_ckh;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ibpp_tok_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibpp_tok_queue
// short token queue between the framing front and the result back
// ----------------------------------------------------------------------------
module ibpp_tok_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ibpp_pkg::t_tok i_tok,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ibpp_pkg::t_tok      o_head
);
    import ibpp_pkg::*;

    t_tok             r_mem [TOK_DEPTH];
    logic [TQ_AW-1:0] r_wp;
    logic [TQ_AW-1:0] r_rp;
    logic [TQ_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (TQ_AW+1)'(TOK_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ibpp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibpp_back
// collects payload bytes, builds result words, holds the result queue
// ----------------------------------------------------------------------------
module ibpp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_tq_empty,
    input  wire ibpp_pkg::t_tok i_tq_head,
    output logic                o_tq_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ibpp_pkg::t_result   o_result
);
    import ibpp_pkg::*;

    logic [7:0]       r_pay [KEEP_BYTES];
    t_result          r_rq [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_AW:0]   r_cnt;

    logic    w_rq_full;
    logic    w_rq_push;
    logic    w_rq_pop;
    t_result w_new;

    assign w_rq_full = (r_cnt == (RQ_AW+1)'(RQ_DEPTH));
    // a result token waits for room, a byte token never stalls
    assign o_tq_pop  = !i_tq_empty && (!i_tq_head.last || !w_rq_full);
    assign w_rq_push = o_tq_pop && i_tq_head.last;
    assign w_rq_pop  = i_pop && (r_cnt != '0);
    assign o_empty   = (r_cnt == '0);
    assign o_result  = r_rq[r_rp];

    always_comb begin
        w_new.kind = i_tq_head.kind;
        if (i_tq_head.kind == KIND_QUAT) begin
            w_new.word_a = {16'd0, r_pay[0], r_pay[1]};
            w_new.word_b = {16'd0, r_pay[2], r_pay[3]};
            w_new.word_c = {16'd0, r_pay[4], r_pay[5]};
            w_new.word_d = {r_pay[6], r_pay[7]};
        end else begin
            w_new.word_a = {r_pay[0], r_pay[1], r_pay[2], r_pay[3]};
            w_new.word_b = {r_pay[4], r_pay[5], r_pay[6], r_pay[7]};
            w_new.word_c = {r_pay[8], r_pay[9], r_pay[10], r_pay[11]};
            w_new.word_d = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tq_pop && !i_tq_head.last && (i_tq_head.idx < IDX_W'(KEEP_BYTES))) begin
            r_pay[i_tq_head.idx] <= i_tq_head.data;
        end
        if (w_rq_push) r_rq[r_wp] <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_rq_push) r_wp <= r_wp + 1'b1;
            if (w_rq_pop) r_rp <= r_rp + 1'b1;
            if (w_rq_push && !w_rq_pop) r_cnt <= r_cnt + 1'b1;
            else if (!w_rq_push && w_rq_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== sv/imu_binary_packet_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imu_binary_packet_parser_top
// binary packet parser for a serial inertial sensor byte stream
// ----------------------------------------------------------------------------
// input channel: one received byte per beat on i_byte_in, taken when i_push
// is high and o_full is low. one byte per cycle is sustained; o_full rises
// only when the four-entry token queue backs up behind a stalled result side.
// result channel: o_empty low means a result is on o_sensor_kind and
// o_word_a..o_word_d; it is taken when i_pop is high. results leave a
// two-entry queue; while it has room a result passes the token queue into the
// registered result queue once the last checksum byte of its packet is accepted.
// at most one result per packet: quaternion, gyro or acceleration, only on a
// matching checksum from an enabled sensor address with a long enough batch.
// configuration: i_cfg_wr writes bit 0 of i_cfg_data to register i_cfg_idx
// (0 orientation, 1 gyro, 2 accel enable) in the same cycle; write only
// while the block is idle.
// reset (i_rst_n low, synchronous) returns to sync hunting, empties both
// queues and clears all enables. a stalled receiver fills the result queue,
// then the token queue, then raises o_full; nothing is lost.
// ----------------------------------------------------------------------------
module imu_binary_packet_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_byte_in,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [1:0]       o_sensor_kind,
    output logic [31:0]      o_word_a,
    output logic [31:0]      o_word_b,
    output logic [31:0]      o_word_c,
    output logic [15:0]      o_word_d,
    input  wire logic        i_cfg_wr,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [0:0]  i_cfg_data
);
    import ibpp_pkg::*;

    t_cfg    r_cfg;
    logic    w_accept;
    logic    w_tq_push;
    t_tok    w_tq_in;
    logic    w_tq_full;
    logic    w_tq_empty;
    logic    w_tq_pop;
    t_tok    w_tq_head;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                CFG_ORIENT: r_cfg.en_orient <= i_cfg_data[0];
                CFG_GYRO:   r_cfg.en_gyro <= i_cfg_data[0];
                CFG_ACCEL:  r_cfg.en_accel <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_full   = w_tq_full;
    assign w_accept = i_push && !w_tq_full;

    ibpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_byte_in),
        .i_cfg      (r_cfg),
        .o_tok_push (w_tq_push),
        .o_tok      (w_tq_in)
    );

    ibpp_tok_queue u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_tq_push),
        .i_tok   (w_tq_in),
        .i_pop   (w_tq_pop),
        .o_full  (w_tq_full),
        .o_empty (w_tq_empty),
        .o_head  (w_tq_head)
    );

    ibpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tq_empty (w_tq_empty),
        .i_tq_head  (w_tq_head),
        .o_tq_pop   (w_tq_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_result   (w_result)
    );

    assign o_sensor_kind = w_result.kind;
    assign o_word_a      = w_result.word_a;
    assign o_word_b      = w_result.word_b;
    assign o_word_c      = w_result.word_c;
    assign o_word_d      = w_result.word_d;

    a_tq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tq_push |-> !w_tq_full)
        else $error("token pushed into a full queue");

    a_tq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tq_pop |-> !w_tq_empty)
        else $error("token popped from an empty queue");

    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tq_pop && w_tq_head.last) |=> !o_empty)
        else $error("result token consumed but no result queued");

endmodule
`default_nettype wire

// ===== sim/imu_binary_packet_parser_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imu_binary_packet_parser_top_tb
// self-checking bench for the binary packet parser
// ----------------------------------------------------------------------------
// a byte-level parser model runs beside the block and predicts every sensor
// reading. a short hand-written stream covers broken sync, a dropped packet,
// an empty batch and one quaternion with its reading typed in. random framed
// packets follow under several enable settings, with noise, broken sync, bad
// checksums and random idling on both sides, plus one long result stall that
// backs the block up until it refuses input bytes.
// ----------------------------------------------------------------------------
module imu_binary_packet_parser_top_tb;
    import ibpp_pkg::*;

    localparam int RUN_LIMIT = 4_000_000;
    localparam int DRAIN_LIMIT = 10_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES = 300;
    localparam int HOLD_CYCLES = 2000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_N    = 3'd1;
    localparam logic [2:0] ST_P    = 3'd2;
    localparam logic [2:0] ST_TYPE = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_PAY  = 3'd5;
    localparam logic [2:0] ST_CKH  = 3'd6;
    localparam logic [2:0] ST_CKL  = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        t_result    res;
    } t_row;

    localparam t_result NO_READING = '0;
    localparam int NUM_DIR = 32;
    localparam t_row DIR_ROWS [NUM_DIR] = '{
        // second 's' is not a new start, so 'n','p' land on a hunting parser
        '{SYNC_S, 1'b0, NO_READING}, '{SYNC_N, 1'b0, NO_READING},
        '{SYNC_S, 1'b0, NO_READING}, '{SYNC_N, 1'b0, NO_READING},
        '{SYNC_P, 1'b0, NO_READING},
        // no data flag: dropped right after the address
        '{SYNC_S, 1'b0, NO_READING}, '{SYNC_N, 1'b0, NO_READING},
        '{SYNC_P, 1'b0, NO_READING}, '{8'h3C, 1'b0, NO_READING},
        '{ADDR_QUAT, 1'b0, NO_READING},
        // zero-length batch: straight to a good checksum, too short for a reading
        '{SYNC_S, 1'b0, NO_READING}, '{SYNC_N, 1'b0, NO_READING},
        '{SYNC_P, 1'b0, NO_READING}, '{8'hC0, 1'b0, NO_READING},
        '{ADDR_GYRO, 1'b0, NO_READING}, '{8'h02, 1'b0, NO_READING},
        '{8'h72, 1'b0, NO_READING},
        // quaternion batch of two, words at the extremes, sum 0x0505
        '{SYNC_S, 1'b0, NO_READING}, '{SYNC_N, 1'b0, NO_READING},
        '{SYNC_P, 1'b0, NO_READING}, '{8'hC8, 1'b0, NO_READING},
        '{ADDR_QUAT, 1'b0, NO_READING},
        '{8'hFF, 1'b0, NO_READING}, '{8'hFF, 1'b0, NO_READING},
        '{8'h00, 1'b0, NO_READING}, '{8'h00, 1'b0, NO_READING},
        '{8'h80, 1'b0, NO_READING}, '{8'h00, 1'b0, NO_READING},
        '{8'h00, 1'b0, NO_READING}, '{8'h01, 1'b0, NO_READING},
        '{8'h05, 1'b0, NO_READING},
        '{8'h05, 1'b1, '{KIND_QUAT, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_8000,
                         16'h0001}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [7:0]  i_byte_in;
    logic        o_empty;
    logic        i_pop;
    logic [1:0]  o_sensor_kind;
    logic [31:0] o_word_a;
    logic [31:0] o_word_b;
    logic [31:0] o_word_c;
    logic [15:0] o_word_d;
    logic        i_cfg_wr;
    logic [1:0]  i_cfg_idx;
    logic [0:0]  i_cfg_data;

    // parser model state
    t_cfg        m_cfg = '0;
    logic [2:0]  m_phase = ST_HUNT;
    logic [7:0]  m_type = '0;
    logic [7:0]  m_addr = '0;
    logic [5:0]  m_len = '0;
    logic [5:0]  m_cnt = '0;
    logic [15:0] m_sum = '0;
    logic [7:0]  m_ckhi = '0;
    logic [7:0]  m_pay [64];

    t_result awaited_readings [$];
    int      n_readings = 0;
    int      n_bytes = 0;
    int      mismatches = 0;
    logic    row_typed = 1'b0;
    t_result row_res = '0;
    int      rx_hold = 0;
    int      tx_left = 0;
    bit      tx_steady = 1'b0;
    int      rx_left = 0;
    bit      rx_steady = 1'b0;

    imu_binary_packet_parser_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_byte_in    (i_byte_in),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_sensor_kind(o_sensor_kind),
        .o_word_a     (o_word_a),
        .o_word_b     (o_word_b),
        .o_word_c     (o_word_c),
        .o_word_d     (o_word_d),
        .i_cfg_wr     (i_cfg_wr),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(inout int run_left, inout bit run_steady);
        if (run_left == 0) begin
            run_steady = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 40);
        end
        run_left--;
        return run_steady ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("MISMATCH at %0t: %s is %h, expected %h", $time, what, seen, wanted);
        mismatches++;
    endtask

    // one received byte through the parser model
    task automatic parse_byte(input logic [7:0] b, output logic got, output t_result r);
        logic [6:0]  len;
        logic [3:0]  blen;
        logic [15:0] rx_sum;
        got = 1'b0;
        r = '0;
        case (m_phase)
            ST_HUNT: if (b == SYNC_S) m_phase = ST_N;
            ST_N:    m_phase = (b == SYNC_N) ? ST_P : ST_HUNT;
            ST_P:    m_phase = (b == SYNC_P) ? ST_TYPE : ST_HUNT;
            ST_TYPE: begin
                m_type = b;
                len = b[BATCH_BIT] ? {1'b0, b[5:2], 2'b00} : 7'd4;
                if (len > MAX_LEN) begin
                    m_phase = ST_HUNT;
                end else begin
                    m_len = len[5:0];
                    m_phase = ST_ADDR;
                end
            end
            ST_ADDR: begin
                m_addr = b;
                m_cnt = '0;
                m_sum = SYNC_SUM + 16'(m_type) + 16'(b);
                if (!m_type[HAS_DATA_BIT]) m_phase = ST_HUNT;
                else if (m_len == '0) m_phase = ST_CKH;
                else m_phase = ST_PAY;
            end
            ST_PAY: begin
                m_pay[m_cnt] = b;
                m_sum = m_sum + 16'(b);
                m_cnt = m_cnt + 6'd1;
                if (m_cnt >= m_len) m_phase = ST_CKH;
            end
            ST_CKH: begin
                m_ckhi = b;
                m_phase = ST_CKL;
            end
            ST_CKL: begin
                rx_sum = {m_ckhi, b};
                blen = m_type[5:2];
                m_phase = ST_HUNT;
                if (rx_sum == m_sum) begin
                    if (m_cfg.en_orient && m_addr == ADDR_QUAT && m_type[BATCH_BIT]
                            && blen >= QUAT_MIN_BATCH) begin
                        got = 1'b1;
                        r.kind = KIND_QUAT;
                        r.word_a = {16'h0, m_pay[0], m_pay[1]};
                        r.word_b = {16'h0, m_pay[2], m_pay[3]};
                        r.word_c = {16'h0, m_pay[4], m_pay[5]};
                        r.word_d = {m_pay[6], m_pay[7]};
                    end else if (((m_cfg.en_gyro && m_addr == ADDR_GYRO)
                            || (m_cfg.en_accel && m_addr == ADDR_ACCEL))
                            && m_type[BATCH_BIT] && blen >= VEC_MIN_BATCH) begin
                        got = 1'b1;
                        r.kind = (m_addr == ADDR_GYRO) ? KIND_GYRO : KIND_ACCEL;
                        r.word_a = {m_pay[0], m_pay[1], m_pay[2], m_pay[3]};
                        r.word_b = {m_pay[4], m_pay[5], m_pay[6], m_pay[7]};
                        r.word_c = {m_pay[8], m_pay[9], m_pay[10], m_pay[11]};
                        r.word_d = '0;
                    end
                end
            end
            default: m_phase = ST_HUNT;
        endcase
    endtask

    always @(posedge i_clk) begin : scoreboard
        logic    got;
        t_result pred;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_wr) begin
                case (i_cfg_idx)
                    CFG_ORIENT: m_cfg.en_orient = i_cfg_data[0];
                    CFG_GYRO:   m_cfg.en_gyro = i_cfg_data[0];
                    CFG_ACCEL:  m_cfg.en_accel = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_pop && o_empty === 1'b0) begin
                if (awaited_readings.size() == 0) begin
                    report_mismatch("reading with none awaited", 32'(o_sensor_kind), '0);
                end else begin
                    want = awaited_readings.pop_front();
                    if (o_sensor_kind !== want.kind)
                        report_mismatch("sensor_kind", 32'(o_sensor_kind), 32'(want.kind));
                    if (o_word_a !== want.word_a)
                        report_mismatch("word_a", o_word_a, want.word_a);
                    if (o_word_b !== want.word_b)
                        report_mismatch("word_b", o_word_b, want.word_b);
                    if (o_word_c !== want.word_c)
                        report_mismatch("word_c", o_word_c, want.word_c);
                    if (o_word_d !== want.word_d)
                        report_mismatch("word_d", 32'(o_word_d), 32'(want.word_d));
                end
            end
            if (i_push && o_full === 1'b0) begin
                parse_byte(i_byte_in, got, pred);
                if (row_typed) begin
                    awaited_readings.push_back(row_res);
                    n_readings++;
                end else if (got) begin
                    awaited_readings.push_back(pred);
                    n_readings++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result res);
        int gap;
        gap = draw_wait(tx_left, tx_steady);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_byte_in <= b;
        row_typed <= typed;
        row_res <= res;
        do @(posedge i_clk); while (!(i_push && o_full === 1'b0));
        n_bytes++;
    endtask

    task automatic write_cfg(input t_cfg c);
        i_cfg_wr <= 1'b1;
        i_cfg_idx <= CFG_ORIENT;
        i_cfg_data <= c.en_orient;
        @(posedge i_clk);
        i_cfg_idx <= CFG_GYRO;
        i_cfg_data <= c.en_gyro;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ACCEL;
        i_cfg_data <= c.en_accel;
        @(posedge i_clk);
        // unused index must be ignored
        i_cfg_idx <= CFG_UNUSED;
        i_cfg_data <= 1'($urandom);
        @(posedge i_clk);
        i_cfg_wr <= 1'b0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        i_push <= 1'b0;
        while (awaited_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_readings.size() != 0) begin
            report_mismatch("readings never delivered", awaited_readings.size(), '0);
            awaited_readings.delete();
        end
    endtask

    // every branch leaves the parser hunting, so enables only change between frames
    task automatic send_packet();
        logic [7:0]  ptype;
        logic [7:0]  addr;
        logic [7:0]  b;
        logic [15:0] sum;
        int          sel;
        int          n_pay;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            repeat ($urandom_range(1, 6)) begin
                b = 8'($urandom);
                if (b == SYNC_S) b = ~b;
                send_byte(b, 1'b0, NO_READING);
            end
        end else if (sel == 1) begin
            send_byte(SYNC_S, 1'b0, NO_READING);
            if ($urandom_range(0, 1) == 1) begin
                send_byte(SYNC_N, 1'b0, NO_READING);
                b = 8'($urandom);
                if (b == SYNC_P) b = ~b;
            end else begin
                b = 8'($urandom);
                if (b == SYNC_N) b = ~b;
            end
            send_byte(b, 1'b0, NO_READING);
        end else begin
            case ($urandom_range(0, 3))
                0: addr = ADDR_QUAT;
                1: addr = ADDR_GYRO;
                2: addr = ADDR_ACCEL;
                default: addr = 8'($urandom);
            endcase
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                ptype = 8'($urandom);
            end else if (sel == 1) begin
                ptype = {2'b10, 6'($urandom)};
            end else begin
                // mostly short batches, now and then any length up to the largest
                ptype = {2'b11, 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(2, 4)),
                         2'($urandom)};
            end
            n_pay = ptype[BATCH_BIT] ? 4 * ptype[5:2] : 4;
            sum = SYNC_SUM + 16'(ptype) + 16'(addr);
            send_byte(SYNC_S, 1'b0, NO_READING);
            send_byte(SYNC_N, 1'b0, NO_READING);
            send_byte(SYNC_P, 1'b0, NO_READING);
            send_byte(ptype, 1'b0, NO_READING);
            send_byte(addr, 1'b0, NO_READING);
            if (ptype[HAS_DATA_BIT]) begin
                repeat (n_pay) begin
                    b = 8'($urandom);
                    sum = sum + 16'(b);
                    send_byte(b, 1'b0, NO_READING);
                end
                if ($urandom_range(0, 7) == 0) sum = sum ^ 16'($urandom_range(1, 65535));
                send_byte(sum[15:8], 1'b0, NO_READING);
                send_byte(sum[7:0], 1'b0, NO_READING);
            end
        end
    endtask

    initial begin : result_sink
        int wait_cycles;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                wait_cycles = rx_hold;
                rx_hold = 0;
            end else begin
                wait_cycles = draw_wait(rx_left, rx_steady);
            end
            if (wait_cycles > 0) begin
                i_pop <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (!(i_pop && o_empty === 1'b0));
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_cfg cfg_plan [5];
        int   phase_start;
        cfg_plan = '{3'b111, 3'b000, 3'b010, 3'b101, 3'b111};
        foreach (m_pay[i]) m_pay[i] = '0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_byte_in = '0;
        i_cfg_wr = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(3'b111);
        for (int k = 0; k < NUM_DIR; k++)
            send_byte(DIR_ROWS[k].data, DIR_ROWS[k].typed, DIR_ROWS[k].res);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(cfg_plan[ph]);
            // long result stall while bytes keep coming
            if (ph == 0) rx_hold = HOLD_CYCLES;
            phase_start = n_bytes;
            while (n_bytes - phase_start < PHASE_BYTES || (ph == 4 && n_readings < 40))
                send_packet();
            drain();
        end

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
